>>> rtl/lsw_pkg.sv
// ----------------------------------------------------------------------------
// lsw_pkg: shared definitions for the sliding window reduction
// Sizes, reduction codes, register indexes and the combine functions used by
// the sample cells and the reduction tree.
// ----------------------------------------------------------------------------
package lsw_pkg;

  localparam int REACH       = 32;
  localparam int SAMPLE_W    = 16;
  localparam int STORE_DEPTH = 2 * REACH + 1;
  localparam int POS_W       = $clog2(STORE_DEPTH + 1);
  localparam int OFF_W       = $clog2(3 * REACH + 1) + 1;
  localparam int LEVELS      = $clog2(STORE_DEPTH);
  localparam int ACC_W       = SAMPLE_W + LEVELS;
  localparam int RESULT_W    = 23;
  localparam int CFG_W       = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int MODE_W      = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_OP_MODE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_START = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_END   = CFG_IDX_W'(2);

  typedef enum logic [MODE_W-1:0] {
    MODE_SUM = 2'd0,
    MODE_MAX = 2'd1,
    MODE_MIN = 2'd2
  } mode_t;

  // Largest and smallest sample, widened to the accumulator.
  localparam logic signed [ACC_W-1:0] ACC_SMAX =
    ACC_W'((64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] ACC_SMIN = ~ACC_SMAX;

  // Window bounds in store offsets, plus the reduction, broadcast to the cells.
  typedef struct packed {
    logic signed [OFF_W-1:0] lo;
    logic signed [OFF_W-1:0] hi;
    logic [MODE_W-1:0]       mode;
  } win_t;

  // Control that travels with one result through the tree.
  typedef struct packed {
    logic              vld;
    logic              last;
    logic [MODE_W-1:0] mode;
  } tag_t;

  function automatic logic signed [ACC_W-1:0] neutral(logic [MODE_W-1:0] mode);
    logic signed [ACC_W-1:0] val;
    case (mode)
      MODE_MAX: val = ACC_SMIN;
      MODE_MIN: val = ACC_SMAX;
      default:  val = '0;
    endcase
    return val;
  endfunction

  function automatic logic signed [ACC_W-1:0] combine(logic [MODE_W-1:0] mode,
                                                      logic signed [ACC_W-1:0] a,
                                                      logic signed [ACC_W-1:0] b);
    logic signed [ACC_W-1:0] val;
    case (mode)
      MODE_MAX: val = (a > b) ? a : b;
      MODE_MIN: val = (a < b) ? a : b;
      default:  val = a + b;
    endcase
    return val;
  endfunction

  // Node count of tree level l (level 0 being the leaves).
  function automatic int lvl_size(int l);
    return (STORE_DEPTH + (1 << l) - 1) >> l;
  endfunction

  // Position of the first node of level lv in the flat node store.
  function automatic int lvl_base(int lv);
    int acc;
    acc = 0;
    for (int l = 1; l < lv; l++) begin
      acc += lvl_size(l);
    end
    return acc;
  endfunction

endpackage

>>> rtl/line_sliding_window_reduce.sv
// ----------------------------------------------------------------------------
// line_sliding_window_reduce: sum, maximum or minimum over a sliding window
// Samples of a line arrive one beat at a time, the last one flagged. For every
// line position q the block returns the sum, maximum or minimum (op_mode 0, 1,
// 2; 3 acts as sum) of the samples q+window_start .. q+window_end, with samples
// outside the line counting as 0, the most negative or the most positive
// sample. Offsets are saturated to +/-32 and window_end is raised to
// window_start when set below it. The result for q is released with the beat
// of sample q+max(window_end,0); the beat that ends the line releases every
// pending result, the final one with last_out set. In steady state the block
// takes one sample and gives one result per clock while the output is not
// stalled. A beat that releases several results (line end, or a shortened lag
// after a window change) holds in_stall until it issues its final result,
// since results enter the reduction tree through a single issue slot, one per
// clock. A result passes a register for the masked cell contributions and then
// the stages of the pairwise tree, which buffer results while the output is
// stalled. Registers may only be written while the block is idle, but need
// not wait for a line to end.
// ----------------------------------------------------------------------------
module line_sliding_window_reduce (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [lsw_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                in_last_in_line,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [lsw_pkg::RESULT_W-1:0] out_result,
  output logic                                out_last_out,
  input  logic                                cfg_we,
  input  logic [lsw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lsw_pkg::CFG_W-1:0]           cfg_wdata
);
  import lsw_pkg::*;

  localparam logic signed [CFG_W-1:0] REACH_P = CFG_W'(REACH);
  localparam logic signed [CFG_W-1:0] REACH_N = CFG_W'(-REACH);

  // Configuration registers.
  logic [MODE_W-1:0]       op_mode_r;
  logic signed [CFG_W-1:0] win_start_r;
  logic signed [CFG_W-1:0] win_end_r;

  // Sequencer state. lag_r counts the line positions still owed a result,
  // pos_r the samples of the current line seen so far (saturating), cur_r
  // the line index of the newest sample and flush_r whether it ended the line.
  logic             go_r;
  logic             go_nxt;
  logic             flush_r;
  logic             flush_nxt;
  logic [POS_W-1:0] lag_r;
  logic [POS_W-1:0] lag_nxt;
  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] pos_nxt;
  logic [POS_W-1:0] cur_r;
  logic [POS_W-1:0] cur_nxt;

  logic signed [CFG_W-1:0] s_val;
  logic signed [CFG_W-1:0] e_raw;
  logic signed [CFG_W-1:0] e_val;
  logic [POS_W-1:0]        lag_max;

  logic             due;
  logic             final_issue;
  logic             issue;
  logic             in_accept;
  logic             leaf_ready;
  logic [POS_W-1:0] lag_m1;
  logic [POS_W-1:0] lag_after;
  logic [POS_W-1:0] lag_inc;

  logic signed [OFF_W-1:0] back_s;
  logic signed [OFF_W-1:0] cur_s;
  logic signed [OFF_W-1:0] lo_s;
  logic signed [OFF_W-1:0] hi_s;
  win_t                    win;
  tag_t                    issue_tag;

  logic signed [SAMPLE_W-1:0] chain [STORE_DEPTH-1];
  logic signed [ACC_W-1:0]    leaf  [STORE_DEPTH];
  logic signed [ACC_W-1:0]    res_value;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_mode_r   <= '0;
      win_start_r <= '0;
      win_end_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OP_MODE:   op_mode_r   <= cfg_wdata[MODE_W-1:0];
        CFG_WIN_START: win_start_r <= cfg_wdata;
        CFG_WIN_END:   win_end_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Effective window: offsets saturated to the reach, the end never below
  // the start. The output lag is the positive part of the end offset.
  always_comb begin
    s_val = (win_start_r > REACH_P) ? REACH_P :
            (win_start_r < REACH_N) ? REACH_N : win_start_r;
    e_raw = (win_end_r > REACH_P) ? REACH_P :
            (win_end_r < REACH_N) ? REACH_N : win_end_r;
    e_val = (e_raw < s_val) ? s_val : e_raw;
    lag_max = e_val[CFG_W-1] ? '0 : POS_W'($unsigned(e_val));
  end

  // Issue control. While the last accepted beat still owes results, one is
  // issued per clock into the tree while the tree accepts; the next beat is taken
  // in the same clock as the final one, so a steady line runs at one beat per clock.
  always_comb begin
    lag_m1      = lag_r - POS_W'(1);
    due         = go_r && (flush_r ? (lag_r != '0) : (lag_r > lag_max));
    final_issue = flush_r ? (lag_r == POS_W'(1)) : (lag_m1 <= lag_max);
    issue       = due && leaf_ready;
    in_stall    = due && !(issue && final_issue);
    in_accept   = in_valid && !in_stall;
    lag_after   = issue ? lag_m1 : lag_r;
    lag_inc     = (lag_after == POS_W'(STORE_DEPTH)) ? lag_after : lag_after + POS_W'(1);
  end

  // The result being issued lies lag_r-1 places behind the newest sample;
  // its window covers store offsets back-end .. back-start, cut off at the
  // first sample of the line.
  always_comb begin
    back_s = OFF_W'(lag_m1);
    cur_s  = OFF_W'(cur_r);
    lo_s   = back_s - OFF_W'(e_val);
    hi_s   = back_s - OFF_W'(s_val);
    win.lo   = lo_s;
    win.hi   = (hi_s < cur_s) ? hi_s : cur_s;
    win.mode = op_mode_r;
    issue_tag.vld  = issue;
    issue_tag.last = flush_r && (lag_r == POS_W'(1));
    issue_tag.mode = op_mode_r;
  end

  always_comb begin
    go_nxt    = in_accept ? 1'b1 : (due && !(issue && final_issue));
    lag_nxt   = in_accept ? lag_inc : lag_after;
    flush_nxt = in_accept ? in_last_in_line : flush_r;
    cur_nxt   = in_accept ? pos_r : cur_r;
    pos_nxt   = pos_r;
    if (in_accept) begin
      if (in_last_in_line) begin
        pos_nxt = '0;
      end else if (pos_r != POS_W'(STORE_DEPTH)) begin
        pos_nxt = pos_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      go_r    <= 1'b0;
      flush_r <= 1'b0;
      lag_r   <= '0;
      pos_r   <= '0;
      cur_r   <= '0;
    end else begin
      go_r    <= go_nxt;
      flush_r <= flush_nxt;
      lag_r   <= lag_nxt;
      pos_r   <= pos_nxt;
      cur_r   <= cur_nxt;
    end
  end

  // Window store: a row of cells, newest sample in cell 0, shifting by one
  // cell on every accepted beat.
  for (genvar j = 0; j < STORE_DEPTH; j++) begin : g_cell
    if (j == 0) begin : g_head
      lsw_cell u_cell (
        .clk        (clk),
        .shift_en   (in_accept),
        .sample_in  (in_sample),
        .sample_out (chain[j]),
        .cell_idx   (POS_W'(j)),
        .load_en    (issue),
        .win        (win),
        .leaf_out   (leaf[j])
      );
    end else if (j == STORE_DEPTH - 1) begin : g_tail
      lsw_cell u_cell (
        .clk        (clk),
        .shift_en   (in_accept),
        .sample_in  (chain[j-1]),
        .sample_out (),
        .cell_idx   (POS_W'(j)),
        .load_en    (issue),
        .win        (win),
        .leaf_out   (leaf[j])
      );
    end else begin : g_body
      lsw_cell u_cell (
        .clk        (clk),
        .shift_en   (in_accept),
        .sample_in  (chain[j-1]),
        .sample_out (chain[j]),
        .cell_idx   (POS_W'(j)),
        .load_en    (issue),
        .win        (win),
        .leaf_out   (leaf[j])
      );
    end
  end

  lsw_tree u_tree (
    .clk        (clk),
    .rst_n      (rst_n),
    .issue_tag  (issue_tag),
    .leaf_ready (leaf_ready),
    .leaf       (leaf),
    .res_valid  (out_valid),
    .res_stall  (out_stall),
    .res_value  (res_value),
    .res_last   (out_last_out)
  );

  assign out_result = RESULT_W'(res_value);

endmodule

>>> rtl/lsw_cell.sv
// ----------------------------------------------------------------------------
// lsw_cell: one sample cell of the window store
// Holds one sample, passes it to the next cell on every accepted beat, and
// registers its masked contribution to the reduction tree.
// ----------------------------------------------------------------------------
module lsw_cell (
  input  logic                                clk,
  input  logic                                shift_en,
  input  logic signed [lsw_pkg::SAMPLE_W-1:0] sample_in,
  output logic signed [lsw_pkg::SAMPLE_W-1:0] sample_out,
  input  logic [lsw_pkg::POS_W-1:0]           cell_idx,
  input  logic                                load_en,
  input  lsw_pkg::win_t                       win,
  output logic signed [lsw_pkg::ACC_W-1:0]    leaf_out
);
  import lsw_pkg::*;

  logic signed [SAMPLE_W-1:0] sample_r;
  logic signed [ACC_W-1:0]    leaf_r;
  logic signed [ACC_W-1:0]    leaf_nxt;
  logic signed [OFF_W-1:0]    idx_s;
  logic                       hit;

  assign idx_s = OFF_W'(cell_idx);
  assign hit   = (idx_s >= win.lo) && (idx_s <= win.hi);

  always_comb begin
    leaf_nxt = hit ? ACC_W'(sample_r) : neutral(win.mode);
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      sample_r <= sample_in;
    end
    if (load_en) begin
      leaf_r <= leaf_nxt;
    end
  end

  assign sample_out = sample_r;
  assign leaf_out   = leaf_r;

endmodule

>>> rtl/lsw_tree.sv
// ----------------------------------------------------------------------------
// lsw_tree: pipelined reduction tree
// Combines the cell contributions pairwise, one tree level per register stage.
// Each stage moves on when the next one is empty or moving, so bubbles close.
// ----------------------------------------------------------------------------
module lsw_tree (
  input  logic                             clk,
  input  logic                             rst_n,
  input  lsw_pkg::tag_t                    issue_tag,
  output logic                             leaf_ready,
  input  logic signed [lsw_pkg::ACC_W-1:0] leaf [lsw_pkg::STORE_DEPTH],
  output logic                             res_valid,
  input  logic                             res_stall,
  output logic signed [lsw_pkg::ACC_W-1:0] res_value,
  output logic                             res_last
);
  import lsw_pkg::*;

  localparam int TREE_NODES = lvl_base(LEVELS + 1);

  tag_t                    tag_r  [LEVELS+1];
  logic [LEVELS:0]         en;
  logic signed [ACC_W-1:0] node_r [TREE_NODES];

  always_comb begin
    en[LEVELS] = !tag_r[LEVELS].vld || !res_stall;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      en[l] = !tag_r[l].vld || en[l+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l <= LEVELS; l++) begin
        tag_r[l] <= '0;
      end
    end else begin
      if (en[0]) begin
        tag_r[0] <= issue_tag;
      end
      for (int l = 1; l <= LEVELS; l++) begin
        if (en[l]) begin
          tag_r[l] <= tag_r[l-1];
        end
      end
    end
  end

  for (genvar lv = 1; lv <= LEVELS; lv++) begin : g_lvl
    localparam int NPREV = lvl_size(lv - 1);
    localparam int NCUR  = lvl_size(lv);
    localparam int BCUR  = lvl_base(lv);
    localparam int BPREV = (lv == 1) ? 0 : lvl_base(lv - 1);

    for (genvar i = 0; i < NCUR; i++) begin : g_node
      logic signed [ACC_W-1:0] a_in;
      logic signed [ACC_W-1:0] b_in;

      if (lv == 1) begin : g_from_leaf
        assign a_in = leaf[2*i];
        if (2 * i + 1 < NPREV) begin : g_pair
          assign b_in = leaf[2*i+1];
        end else begin : g_odd
          assign b_in = neutral(tag_r[0].mode);
        end
      end else begin : g_from_node
        assign a_in = node_r[BPREV + 2*i];
        if (2 * i + 1 < NPREV) begin : g_pair
          assign b_in = node_r[BPREV + 2*i + 1];
        end else begin : g_odd
          assign b_in = neutral(tag_r[lv-1].mode);
        end
      end

      always_ff @(posedge clk) begin
        if (en[lv]) begin
          node_r[BCUR + i] <= combine(tag_r[lv-1].mode, a_in, b_in);
        end
      end
    end
  end

  assign leaf_ready = en[0];
  assign res_valid  = tag_r[LEVELS].vld;
  assign res_last   = tag_r[LEVELS].last;
  assign res_value  = node_r[lvl_base(LEVELS)];

endmodule

>>> rtl/lsw_checker.sv
// ----------------------------------------------------------------------------
// lsw_checker: port checks for the sliding window reduction
// Watches the top level's ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
module lsw_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [lsw_pkg::RESULT_W-1:0] out_result,
  input logic                                out_last_out
);

  // A result beat held back by the receiver stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result) && $stable(out_last_out))
    else $error("result beat changed while stalled");

  // Reset leaves no result pending and the input open.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  // Only a freshly accepted sample can make the block hold its input.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(in_valid && !in_stall))
    else $error("input stalled without a preceding sample beat");

endmodule

bind line_sliding_window_reduce lsw_checker u_lsw_checker (.*);
